FILE: rtl/core/fslm_pkg.sv
// fslm_pkg: shared constants, types and helpers for the fixed string line matcher.
// No dependencies; imported by every module in rtl/core.
package fslm_pkg;

    localparam int MAX_PATTERN  = 16;
    localparam int PAT_IDX_W    = $clog2(MAX_PATTERN);
    localparam int PAT_LEN_W    = 5;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam logic [7:0]  NEWLINE        = 8'd10;
    localparam logic [31:0] LINE_COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] LINE_COUNT_ONE = 32'd1;

    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        REG_IGNORE_CASE   = 3'd0,
        REG_STOP_AT_FIRST = 3'd1,
        REG_PATTERN_LEN   = 3'd2,
        REG_PATTERN_LOW   = 3'd3,
        REG_PATTERN_HIGH  = 3'd4
    } t_reg_idx;

    // settings seen by the compare logic
    typedef struct packed {
        logic                 ignore_case;
        logic [PAT_LEN_W-1:0] length;      // already clamped to MAX_PATTERN
        logic [127:0]         pattern;
    } t_cmp_cfg;

    typedef struct packed {
        logic       push;
        logic       clear;
        logic [7:0] text_byte;
    } t_win_ctl;

    typedef struct packed {
        logic        kind;
        logic [31:0] line_number;
        logic        found;
        logic        last;
    } t_result;

    function automatic logic [7:0] fold(input logic ic, input logic [7:0] c);
        if (ic && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/fslm_window.sv
// fslm_window: last bytes of the current line and the parallel tail compare.
// Depends on fslm_pkg.
module fslm_window import fslm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_win_ctl i_ctl,
    input  t_cmp_cfg i_cfg,
    output logic     o_hit
);

    logic [7:0]           r_window [MAX_PATTERN];
    logic [7:0]           n_window [MAX_PATTERN];
    logic [PAT_LEN_W-1:0] r_bytes;
    logic [PAT_LEN_W-1:0] n_bytes;
    logic [7:0]           pat_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pos_ok;
    logic [PAT_LEN_W-1:0] pidx;

    // window after the incoming byte is shifted in, newest first
    always_comb begin
        n_window[0] = i_ctl.text_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_window[k] = r_window[k-1];
        end
        n_bytes = (r_bytes == PAT_LEN_W'(MAX_PATTERN)) ? r_bytes : r_bytes + PAT_LEN_W'(1);
    end

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pat_byte[k] = i_cfg.pattern[k*8 +: 8];
        end
    end

    // position k of the window lines up with pattern byte length-1-k
    always_comb begin
        pidx = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pidx = i_cfg.length - PAT_LEN_W'(1) - PAT_LEN_W'(k);
            pos_ok[k] = (PAT_LEN_W'(k) >= i_cfg.length) ||
                        (fold(i_cfg.ignore_case, n_window[k]) ==
                         fold(i_cfg.ignore_case, pat_byte[pidx[PAT_IDX_W-1:0]]));
        end
        o_hit = i_ctl.push && (i_cfg.length != '0) && (n_bytes >= i_cfg.length) && (&pos_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_window[k] <= '0;
            end
            r_bytes <= '0;
        end else if (i_ctl.push) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_window[k] <= n_window[k];
            end
            r_bytes <= n_bytes;
        end
    end

endmodule

FILE: rtl/core/fslm_queue.sv
// fslm_queue: result queue, up to two in a cycle, one out unless stalled.
// Depends on fslm_pkg.
module fslm_queue import fslm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_push_cnt,
    input  t_result     i_r0,
    input  t_result     i_r1,
    output logic        o_hold,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_result
);

    t_result           r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              pop;
    logic [QPTR_W-1:0] wr_plus1;

    assign o_out_valid = (r_count != '0);
    assign o_result    = r_q[r_rd];
    assign pop         = o_out_valid && !i_out_stall;
    assign wr_plus1    = r_wr + QPTR_W'(1);

    // room for this cycle's results plus a worst-case request next cycle
    assign o_hold = ({1'b0, r_count} + {2'b00, i_push_cnt} + 4'd2) > 4'(QUEUE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_q[r_wr] <= i_r0;
        end
        if (i_push_cnt == 2'd2) begin
            r_q[wr_plus1] <= i_r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + i_push_cnt[QPTR_W-1:0];
            r_rd    <= r_rd + QPTR_W'(pop);
            r_count <= r_count + QCNT_W'(i_push_cnt) - QCNT_W'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_room_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_hold |=> ({1'b0, r_count} + 4'd2 <= 4'(QUEUE_DEPTH)))
        else $error("no room left for next request");

    a_push_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_cnt != 2'd3)
        else $error("bad push count");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt == 2'd2) |-> (i_r1.last && !i_r0.last && i_r1.kind == KIND_END))
        else $error("result pair out of order");
`endif

endmodule

FILE: rtl/core/fixed_string_line_matcher.sv
// fixed_string_line_matcher: top level, register port, line control, result queue.
// Depends on fslm_pkg, fslm_window, fslm_queue.
//
//  channel  direction  handshake                 payload
//  in       request    i_in_valid / o_in_stall   i_text_byte, i_end_of_stream
//  out      result     o_out_valid / i_out_stall o_kind, o_line_number, o_found, o_last
//  cfg      APB write  psel, penable, pwrite     paddr, pwdata, prdata
//
// One byte per cycle unless o_in_stall is high: a request is registered, then
// compared against the pattern and the line state in the next cycle; results
// land in a four-entry queue, which registers each result before it appears.
// o_in_stall rises only when the queue could not take two more results.
// Reset is synchronous and returns all stream state and registers to zero,
// line counter to one; no clearing pass is needed.
module fixed_string_line_matcher import fslm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [31:0] o_line_number,
    output logic        o_found,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_eos;

    logic                 r_ignore_case;
    logic                 r_stop_at_first;
    logic [PAT_LEN_W-1:0] r_pattern_length;
    logic [63:0]          r_pattern_low;
    logic [63:0]          r_pattern_high;

    logic [31:0]          r_line_count;
    logic [31:0]          n_line_count;
    logic                 r_line_has_match;
    logic                 n_line_has_match;
    logic                 r_stream_found;
    logic                 n_stream_found;
    logic                 r_stopped;
    logic                 n_stopped;

    t_win_ctl             win_ctl;
    t_cmp_cfg             cmp_cfg;
    logic                 hit;
    logic                 in_accept;
    logic                 cfg_write;
    t_reg_idx             reg_idx;
    logic                 active;
    logic                 is_nl;
    logic                 line_end;
    logic                 line_rep;
    logic                 end_rep;
    logic                 has_match;
    logic                 found_now;
    logic [1:0]           push_cnt;
    t_result              res0;
    t_result              res1;
    t_result              q_out;
    logic                 hold;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = t_reg_idx'(paddr[5:3]);
    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = hold;

    always_comb begin
        case (reg_idx)
            REG_IGNORE_CASE:   prdata = {63'd0, r_ignore_case};
            REG_STOP_AT_FIRST: prdata = {63'd0, r_stop_at_first};
            REG_PATTERN_LEN:   prdata = {59'd0, r_pattern_length};
            REG_PATTERN_LOW:   prdata = r_pattern_low;
            REG_PATTERN_HIGH:  prdata = r_pattern_high;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_case    <= 1'b0;
            r_stop_at_first  <= 1'b0;
            r_pattern_length <= '0;
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_IGNORE_CASE:   r_ignore_case    <= pwdata[0];
                REG_STOP_AT_FIRST: r_stop_at_first  <= pwdata[0];
                REG_PATTERN_LEN:   r_pattern_length <= pwdata[PAT_LEN_W-1:0];
                REG_PATTERN_LOW:   r_pattern_low    <= pwdata;
                REG_PATTERN_HIGH:  r_pattern_high   <= pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_text_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    always_comb begin
        cmp_cfg.ignore_case = r_ignore_case;
        cmp_cfg.length      = (r_pattern_length > PAT_LEN_W'(MAX_PATTERN)) ?
                              PAT_LEN_W'(MAX_PATTERN) : r_pattern_length;
        cmp_cfg.pattern     = {r_pattern_high, r_pattern_low};
    end

    always_comb begin
        is_nl    = (r_in_byte == NEWLINE);
        active   = r_in_valid && !r_stopped;
        line_end = active && (is_nl || r_in_eos);
        end_rep  = r_in_valid && r_in_eos;

        win_ctl.push      = active && !is_nl;
        win_ctl.clear     = line_end || end_rep;
        win_ctl.text_byte = r_in_byte;

        has_match = r_line_has_match || hit;
        line_rep  = line_end && (has_match || cmp_cfg.length == '0);
        found_now = r_stream_found || line_rep;
        push_cnt  = {1'b0, line_rep} + {1'b0, end_rep};
    end

    always_comb begin
        res1.kind        = KIND_END;
        res1.line_number = '0;
        res1.found       = found_now;
        res1.last        = 1'b1;
        if (line_rep) begin
            res0.kind        = KIND_LINE;
            res0.line_number = r_line_count;
            res0.found       = 1'b1;
            res0.last        = !end_rep;
        end else begin
            res0 = res1;
        end
    end

    always_comb begin
        n_line_count     = r_line_count;
        n_line_has_match = r_line_has_match;
        n_stream_found   = found_now;
        n_stopped        = r_stopped;
        if (active) begin
            n_line_has_match = has_match;
        end
        if (line_end) begin
            n_line_has_match = 1'b0;
            if (r_line_count != LINE_COUNT_MAX) begin
                n_line_count = r_line_count + 32'd1;
            end
        end
        if (line_rep && r_stop_at_first) begin
            n_stopped = 1'b1;
        end
        // end of stream: back to a fresh stream
        if (end_rep) begin
            n_line_count     = LINE_COUNT_ONE;
            n_line_has_match = 1'b0;
            n_stream_found   = 1'b0;
            n_stopped        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count     <= LINE_COUNT_ONE;
            r_line_has_match <= 1'b0;
            r_stream_found   <= 1'b0;
            r_stopped        <= 1'b0;
        end else begin
            r_line_count     <= n_line_count;
            r_line_has_match <= n_line_has_match;
            r_stream_found   <= n_stream_found;
            r_stopped        <= n_stopped;
        end
    end

    fslm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (win_ctl),
        .i_cfg   (cmp_cfg),
        .o_hit   (hit)
    );

    fslm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (push_cnt),
        .i_r0        (res0),
        .i_r1        (res1),
        .o_hold      (hold),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (q_out)
    );

    assign o_kind        = q_out.kind;
    assign o_line_number = q_out.line_number;
    assign o_found       = q_out.found;
    assign o_last        = q_out.last;

endmodule

FILE: tb/sv/fixed_string_line_matcher_test.sv
`timescale 1ns / 100ps
// fixed_string_line_matcher_test: self-checking bench for the fixed string line matcher.
// Sends text requests with random gaps, programs the pattern over APB, predicts line
// and end-of-stream reports locally and checks each one. Depends on fslm_pkg and the RTL.
module fixed_string_line_matcher_test import fslm_pkg::*;;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int TARGET_BYTES  = 1000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_WAIT      = 19;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } t_text_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_text_byte = 8'd0;
    logic        i_end_of_stream = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_kind;
    logic [31:0] o_line_number;
    logic        o_found;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = 6'd0;
    logic [63:0] pwdata = 64'd0;
    logic [63:0] prdata;
    logic        pready;

    fixed_string_line_matcher uut (.*);

    always #6 i_clk = ~i_clk;

    // register copies
    logic         cfg_fold = 1'b0;
    logic         cfg_stop = 1'b0;
    logic [4:0]   cfg_len = 5'd0;
    logic [127:0] cfg_pattern = 128'd0;

    // line search state, newest byte in win[0]
    logic [7:0]   win [MAX_PATTERN];
    int unsigned  line_bytes;
    logic [31:0]  line_no;
    logic         line_hit;
    logic         stream_hit;
    logic         halted;

    t_text_req    text_queue[$];
    t_result      pending_reports[$];
    int unsigned  queued_total = 0;
    int unsigned  taken_total = 0;
    int unsigned  bytes_scanned = 0;
    int unsigned  line_reports = 0;
    int unsigned  end_reports = 0;
    int unsigned  phases = 0;
    int unsigned  errors = 0;
    int unsigned  cycles = 0;

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (cfg_fold && c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic int unsigned used_len();
        return (cfg_len > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_len);
    endfunction

    // pattern ends at the newest byte of the line
    function automatic bit tail_hit();
        int unsigned n;
        n = used_len();
        if (line_bytes < n) return 1'b0;
        for (int unsigned k = 0; k < n; k++) begin
            if (lower(win[k]) != lower(cfg_pattern[8*(n-1-k) +: 8])) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_line();
        for (int k = 0; k < MAX_PATTERN; k++) win[k] = 8'd0;
        line_bytes = 0;
        line_hit = 1'b0;
    endfunction

    function automatic void clear_stream();
        clear_line();
        line_no = LINE_COUNT_ONE;
        stream_hit = 1'b0;
        halted = 1'b0;
    endfunction

    function automatic void add_report(input logic kind, input logic [31:0] num,
                                       input logic found, input logic is_last);
        t_result r;
        r.kind = kind;
        r.line_number = num;
        r.found = found;
        r.last = is_last;
        pending_reports.push_back(r);
    endfunction

    function automatic void scan_byte(input logic [7:0] c, input logic eos);
        if (!halted) begin
            bytes_scanned++;
            if (c != NEWLINE) begin
                for (int k = MAX_PATTERN - 1; k > 0; k--) win[k] = win[k-1];
                win[0] = c;
                if (line_bytes < MAX_PATTERN) line_bytes++;
                if (used_len() > 0 && tail_hit()) line_hit = 1'b1;
            end
            if (c == NEWLINE || eos) begin
                if (line_hit || used_len() == 0) begin
                    stream_hit = 1'b1;
                    add_report(KIND_LINE, line_no, 1'b1, !eos);
                    line_reports++;
                    if (cfg_stop) halted = 1'b1;
                end
                if (line_no != LINE_COUNT_MAX) line_no++;
                clear_line();
            end
        end
        if (eos) begin
            add_report(KIND_END, 32'd0, stream_hit, 1'b1);
            end_reports++;
            clear_stream();
        end
    endfunction

    // request driver
    int unsigned send_wait = 0;
    bit          send_burst = 1'b0;
    always @(posedge i_clk) begin
        t_text_req req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) begin
                taken_total++;
                scan_byte(i_text_byte, i_end_of_stream);
                if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
                send_wait = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (send_wait > 0) begin
                send_wait--;
                i_in_valid <= 1'b0;
            end else if (text_queue.size() > 0) begin
                req = text_queue.pop_front();
                i_in_valid <= 1'b1;
                i_text_byte <= req.ch;
                i_end_of_stream <= req.eos;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    int unsigned recv_wait = 0;
    bit          recv_burst = 1'b0;
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_reports.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: kind %0d line %0d found %0d last %0d",
                                 o_kind, o_line_number, o_found, o_last);
                end else begin
                    want = pending_reports.pop_front();
                    if (o_kind !== want.kind || o_line_number !== want.line_number ||
                        o_found !== want.found || o_last !== want.last) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: expected kind %0d line %0d found %0d last %0d",
                                     want.kind, want.line_number, want.found, want.last);
                            $display("          got kind %0d line %0d found %0d last %0d",
                                     o_kind, o_line_number, o_found, o_last);
                        end
                    end
                end
                if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (o_out_valid && recv_wait > 0) begin
                recv_wait--;
            end
            i_out_stall <= (recv_wait != 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_reports.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_IGNORE_CASE:   cfg_fold = value[0];
            REG_STOP_AT_FIRST: cfg_stop = value[0];
            REG_PATTERN_LEN:   cfg_len = value[4:0];
            REG_PATTERN_LOW:   cfg_pattern[63:0] = value;
            REG_PATTERN_HIGH:  cfg_pattern[127:64] = value;
            default: ;
        endcase
    endtask

    function automatic void send(input logic [7:0] c, input logic eos);
        t_text_req req;
        req.ch = c;
        req.eos = eos;
        text_queue.push_back(req);
        queued_total++;
    endfunction

    function automatic void send_text(input string s, input logic eos_on_last);
        for (int i = 0; i < s.len(); i++) send(s[i], eos_on_last && i == s.len() - 1);
    endfunction

    // block may still hold a request that gives no result, so settle before writes
    task automatic drain();
        while (taken_total != queued_total) @(posedge i_clk);
        while (pending_reports.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 3))
            0: return "a";
            1: return "A";
            2: return "b";
            default: return "B";
        endcase
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    task automatic random_phase();
        logic [127:0] pat;
        logic [4:0]   plen;
        logic         fold_on;
        int unsigned  eff;
        int unsigned  lines;
        int unsigned  len;
        int unsigned  ending;
        logic [7:0]   chars[$];
        logic [7:0]   c;

        phases++;
        case ($urandom_range(0, 7))
            0: pat = '1;
            1: pat = '0;
            default: begin
                for (int i = 0; i < MAX_PATTERN; i++) begin
                    case ($urandom_range(0, 29))
                        0:       pat[8*i +: 8] = NEWLINE;
                        1, 2, 3: pat[8*i +: 8] = 8'($urandom_range(0, 255));
                        default: pat[8*i +: 8] = pick_letter();
                    endcase
                end
            end
        endcase
        case ($urandom_range(0, 7))
            0: plen = 5'd0;
            1: plen = 5'd16;
            2: plen = 5'($urandom_range(17, 31));
            default: plen = 5'($urandom_range(1, 6));
        endcase
        fold_on = 1'($urandom_range(0, 1));
        eff = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;

        write_reg(REG_IGNORE_CASE, 64'(fold_on));
        write_reg(REG_STOP_AT_FIRST, 64'($urandom_range(0, 3) == 0));
        write_reg(REG_PATTERN_LEN, 64'(plen));
        write_reg(REG_PATTERN_LOW, pat[63:0]);
        write_reg(REG_PATTERN_HIGH, pat[127:64]);

        lines = $urandom_range(1, 8);
        for (int ln = 0; ln < lines; ln++) begin
            chars.delete();
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 12);
            while (chars.size() < len) begin
                case ($urandom_range(0, 19))
                    0, 1, 2: chars.push_back(8'($urandom_range(0, 255)));
                    3, 4, 5: begin
                        // drop a copy of the pattern in, case flipped now and then
                        for (int j = 0; j < eff; j++) begin
                            c = pat[8*j +: 8];
                            if (is_letter(c) && $urandom_range(0, 9) < (fold_on ? 5 : 1))
                                c = c ^ 8'h20;
                            chars.push_back(c);
                        end
                    end
                    default: chars.push_back(pick_letter());
                endcase
            end
            ending = $urandom_range(0, 9);
            if (ln == lines - 1 && $urandom_range(0, 2) == 0) begin
                // leave the line open across the next register writes
                foreach (chars[i]) send(chars[i], 1'b0);
            end else if (ending == 0 && chars.size() > 0) begin
                foreach (chars[i]) send(chars[i], i == chars.size() - 1);
            end else begin
                foreach (chars[i]) send(chars[i], 1'b0);
                send(NEWLINE, ending <= 1);
            end
        end
        drain();
    endtask

    initial begin
        clear_stream();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty pattern, every line matches, empty line too
        send_text("\nq", 1'b0);
        send(NEWLINE, 1'b1);
        drain();

        // folded compare, byte extremes, match in an unterminated last line
        write_reg(REG_IGNORE_CASE, 64'd1);
        write_reg(REG_STOP_AT_FIRST, 64'd0);
        write_reg(REG_PATTERN_LEN, 64'd2);
        write_reg(REG_PATTERN_LOW, 64'h6241);
        write_reg(REG_PATTERN_HIGH, 64'd0);
        send(8'hFF, 1'b0);
        send(8'h00, 1'b0);
        send_text("aB\nab", 1'b1);
        drain();

        // stop mode: first match only, rest ignored until end of stream
        write_reg(REG_IGNORE_CASE, 64'd0);
        write_reg(REG_STOP_AT_FIRST, 64'd1);
        write_reg(REG_PATTERN_LEN, 64'd1);
        write_reg(REG_PATTERN_LOW, 64'h7A);
        send_text("z\nz\nz", 1'b1);
        drain();

        while (queued_total < TARGET_BYTES) random_phase();
        drain();

        $display("scanned %0d text bytes under %0d random register settings",
                 bytes_scanned, phases);
        $display("checked %0d line reports and %0d end-of-stream reports, %0d errors",
                 line_reports, end_reports, errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
